// ===== sv/fhe_pkg.sv =====
// ----------------------------------------------------------------------------
// fhe_pkg: shared definitions of the fire heat effect
// Widths, register map, reset values, datapath commands and status types.
// ----------------------------------------------------------------------------
package fhe_pkg;

    localparam int CELLS_DEF      = 64;
    localparam int SPARK_ZONE_DEF = 7;

    // Field widths
    localparam int PIX_W     = 6;
    localparam int COLOR_W   = 8;
    localparam int HEAT_W    = 8;
    localparam int ROLL_W    = 8;
    localparam int CELL_W    = 3;
    localparam int BOOST_W   = 8;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    // Configuration port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_COOLING      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SPARK_THR    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_PERIOD = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PALETTE      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_NOISE_SEED   = 3'd4;

    localparam int PERIOD_W = 10;
    localparam int SEED_W   = 16;

    localparam logic [7:0]          COOLING_RST   = 8'd55;
    localparam logic [7:0]          SPARK_THR_RST = 8'd120;
    localparam logic [PERIOD_W-1:0] PERIOD_RST    = 10'd15;
    localparam logic [1:0]          PALETTE_RST   = 2'd0;
    localparam logic [SEED_W-1:0]   SEED_RST      = 16'd1;

    localparam logic [1:0] PAL_RED   = 2'd0;
    localparam logic [1:0] PAL_GREEN = 2'd1;

    localparam logic [SEED_W-1:0] LFSR_MASK = 16'hB400;

    // Shared divider
    localparam int DIV_NUM_W     = 16;
    localparam int DIV_DEN_W     = 9;
    localparam int DIV_BITS_STEP = 4;

    typedef struct packed {
        logic [7:0]          cooling;
        logic [7:0]          spark_thr;
        logic [PERIOD_W-1:0] frame_period;
        logic [1:0]          palette;
    } t_cfg;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LATCH,
        DP_SPAN_GO,
        DP_SPAN_SET,
        DP_COOL_GO,
        DP_COOL_WR,
        DP_DIFF_RD,
        DP_DIFF_SUM,
        DP_DIFF_WR,
        DP_SPARK_RD,
        DP_SPARK_WR,
        DP_EMIT_RD,
        DP_EMIT_CALC,
        DP_EMIT_LD
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   last;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic out_free;
        logic spark_hit;
    } t_dp_stat;

    // Galois LFSR, shifting right.
    function automatic logic [SEED_W-1:0] lfsr_next(input logic [SEED_W-1:0] v);
        logic [SEED_W-1:0] s;
        s = v >> 1;
        if (v[0]) begin
            s = s ^ LFSR_MASK;
        end
        return s;
    endfunction

endpackage

// ===== sv/fire_heat_effect.sv =====
// ----------------------------------------------------------------------------
// fire_heat_effect: heat-cell fire effect generator
// One input beat is one millisecond tick; frames of pixel colors come out.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata: spark_roll[7:0], spark_cell[10:8],
//                        spark_boost[18:11], zero fill
//   m_axis    out        tdata: pixel_index[5:0], red[13:6], green[21:14],
//                        blue[29:22], zero fill; tlast: last_pixel
//   APB       in/out     cooling, spark_threshold, frame_period, palette,
//                        noise_seed at byte offsets 0, 4, 8, 12, 16
//
// A tick that brings no frame is taken in the idle state. In a frame tick
// the cooling pass dominates, waiting on the shared divider for each cell.
// Reset is synchronous; after it the next tick emits a frame. A stalled
// output holds the frame walk at the pixel being loaded; ticks are refused
// until the last pixel of a frame sits in the output register.
// ----------------------------------------------------------------------------
module fire_heat_effect #(
    parameter int CELLS      = fhe_pkg::CELLS_DEF,
    parameter int SPARK_ZONE = fhe_pkg::SPARK_ZONE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // spark_roll, spark_cell, spark_boost from bit 0 up
    input  logic [fhe_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // pixel_index, red, green, blue from bit 0 up
    output logic [fhe_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    output logic                           o_m_axis_tlast,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fhe_pkg::APB_AW-1:0]     paddr,
    input  logic [fhe_pkg::APB_DW-1:0]     pwdata,
    output logic [fhe_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);
    import fhe_pkg::*;

    t_cfg                     cfg;
    logic                     seed_load;
    logic [SEED_W-1:0]        seed;
    t_dp_cmd                  cmd;
    t_dp_stat                 stat;
    logic [$clog2(CELLS)-1:0] idx;

    fhe_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_cfg       (cfg),
        .o_seed_load (seed_load),
        .o_seed      (seed)
    );

    fhe_ctrl #(
        .CELLS (CELLS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (i_s_axis_tvalid),
        .o_s_tready     (o_s_axis_tready),
        .i_frame_period (cfg.frame_period),
        .i_stat         (stat),
        .o_cmd          (cmd),
        .o_idx          (idx)
    );

    fhe_dp #(
        .CELLS      (CELLS),
        .SPARK_ZONE (SPARK_ZONE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_idx       (idx),
        .i_cfg       (cfg),
        .i_seed_load (seed_load),
        .i_seed      (seed),
        .i_s_tdata   (i_s_axis_tdata),
        .o_stat      (stat),
        .o_m_tvalid  (o_m_axis_tvalid),
        .o_m_tdata   (o_m_axis_tdata),
        .o_m_tlast   (o_m_axis_tlast),
        .i_m_tready  (i_m_axis_tready)
    );

endmodule

// ===== sv/fhe_cfg.sv =====
// ----------------------------------------------------------------------------
// fhe_cfg: configuration registers
// APB-style register file; a seed write also reloads the noise generator.
// ----------------------------------------------------------------------------
module fhe_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fhe_pkg::APB_AW-1:0]  paddr,
    input  logic [fhe_pkg::APB_DW-1:0]  pwdata,
    output logic [fhe_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output fhe_pkg::t_cfg               o_cfg,
    output logic                        o_seed_load,
    output logic [fhe_pkg::SEED_W-1:0]  o_seed
);
    import fhe_pkg::*;

    t_cfg                 r_cfg;
    logic [SEED_W-1:0]    r_seed;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cooling      <= COOLING_RST;
            r_cfg.spark_thr    <= SPARK_THR_RST;
            r_cfg.frame_period <= PERIOD_RST;
            r_cfg.palette      <= PALETTE_RST;
            r_seed             <= SEED_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_COOLING:      r_cfg.cooling      <= pwdata[7:0];
                REG_SPARK_THR:    r_cfg.spark_thr    <= pwdata[7:0];
                REG_FRAME_PERIOD: r_cfg.frame_period <= pwdata[PERIOD_W-1:0];
                REG_PALETTE:      r_cfg.palette      <= pwdata[1:0];
                REG_NOISE_SEED:   r_seed             <= pwdata[SEED_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_COOLING:      prdata = APB_DW'(r_cfg.cooling);
            REG_SPARK_THR:    prdata = APB_DW'(r_cfg.spark_thr);
            REG_FRAME_PERIOD: prdata = APB_DW'(r_cfg.frame_period);
            REG_PALETTE:      prdata = APB_DW'(r_cfg.palette);
            REG_NOISE_SEED:   prdata = APB_DW'(r_seed);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg       = r_cfg;
    assign o_seed      = pwdata[SEED_W-1:0];
    assign o_seed_load = wr_en && (reg_idx == REG_NOISE_SEED);

endmodule

// ===== sv/fhe_div.sv =====
// ----------------------------------------------------------------------------
// fhe_div: iterative unsigned divider
// Restoring division, a few quotient bits per cycle.
// ----------------------------------------------------------------------------
module fhe_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [fhe_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [fhe_pkg::DIV_DEN_W-1:0] i_den,
    output logic                          o_busy,
    output logic [fhe_pkg::DIV_NUM_W-1:0] o_quot,
    output logic [fhe_pkg::DIV_DEN_W-1:0] o_rem
);
    import fhe_pkg::*;

    localparam int STEPS = DIV_NUM_W / DIV_BITS_STEP;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_NUM_W-1:0] r_quot;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_NUM_W-1:0] n_quot;
    logic [DIV_DEN_W-1:0] n_rem;
    logic [DIV_DEN_W:0]   trial;

    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        trial  = '0;
        for (int s = 0; s < DIV_BITS_STEP; s++) begin
            trial  = {n_rem, n_quot[DIV_NUM_W-1]};
            n_quot = {n_quot[DIV_NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                trial     = trial - {1'b0, r_den};
                n_quot[0] = 1'b1;
            end
            n_rem = trial[DIV_DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_cnt != '0) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ===== sv/fhe_dp.sv =====
// ----------------------------------------------------------------------------
// fhe_dp: fire effect datapath
// Heat memory, noise generator, cooling, diffusion, spark and color mapping.
// ----------------------------------------------------------------------------
module fhe_dp #(
    parameter int CELLS      = fhe_pkg::CELLS_DEF,
    parameter int SPARK_ZONE = fhe_pkg::SPARK_ZONE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  fhe_pkg::t_dp_cmd                 i_cmd,
    input  logic [$clog2(CELLS)-1:0]         i_idx,
    input  fhe_pkg::t_cfg                    i_cfg,
    input  logic                             i_seed_load,
    input  logic [fhe_pkg::SEED_W-1:0]       i_seed,
    input  logic [fhe_pkg::S_TDATA_W-1:0]    i_s_tdata,
    output fhe_pkg::t_dp_stat                o_stat,
    output logic                             o_m_tvalid,
    output logic [fhe_pkg::M_TDATA_W-1:0]    o_m_tdata,
    output logic                             o_m_tlast,
    input  logic                             i_m_tready
);
    import fhe_pkg::*;

    localparam int AW = $clog2(CELLS);

    logic [HEAT_W-1:0]    r_heat [CELLS];
    logic [HEAT_W-1:0]    r_rd_a;
    logic [HEAT_W-1:0]    r_rd_b;
    logic [SEED_W-1:0]    r_lfsr;
    logic                 r_warm;
    logic [DIV_DEN_W-1:0] r_span;
    logic                 r_hit;
    logic [AW-1:0]        r_spark_y;
    logic [BOOST_W-1:0]   r_boost;
    logic [9:0]           r_sum;
    logic [COLOR_W-1:0]   r_tone;
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    logic                 r_out_last;

    logic                 rd_a_en;
    logic                 rd_b_en;
    logic [AW-1:0]        rd_a_addr;
    logic [AW-1:0]        rd_b_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [HEAT_W-1:0]    wr_data;

    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_busy;
    logic [DIV_NUM_W-1:0] div_quot;
    logic [DIV_DEN_W-1:0] div_rem;

    logic [SEED_W-1:0]    lfsr_step;
    logic [HEAT_W-1:0]    cool_h;
    logic [HEAT_W-1:0]    cool_val;
    logic [19:0]          diff_prod;
    logic [ROLL_W-1:0]    in_roll;
    logic [CELL_W-1:0]    in_cell;
    logic [BOOST_W-1:0]   in_boost;
    logic [3:0]           zone_v;
    logic [15:0]          tone_x;
    logic [16:0]          tone_q;
    logic [COLOR_W-1:0]   ramp;
    logic                 band_hot;
    logic                 band_mid;
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   green;
    logic [COLOR_W-1:0]   blue;
    logic                 out_free;

    assign in_roll  = i_s_tdata[ROLL_W-1:0];
    assign in_cell  = i_s_tdata[ROLL_W+CELL_W-1:ROLL_W];
    assign in_boost = i_s_tdata[ROLL_W+CELL_W+BOOST_W-1:ROLL_W+CELL_W];

    assign lfsr_step = lfsr_next(r_lfsr);
    assign out_free  = !r_out_valid || i_m_tready;

    // Spark cell folded into the spark zone by repeated subtraction.
    always_comb begin
        zone_v = 4'(in_cell);
        for (int k = 0; k < 8; k++) begin
            if (zone_v >= 4'(SPARK_ZONE)) begin
                zone_v = zone_v - 4'(SPARK_ZONE);
            end
        end
    end

    // Cells read as zero until the first cooling pass has written them all.
    assign cool_h   = r_warm ? r_rd_a : '0;
    assign cool_val = ({1'b0, cool_h} < div_rem) ? '0 : (cool_h - div_rem[HEAT_W-1:0]);

    // Division by three as a multiply by 683/2048, exact for sums below 768.
    assign diff_prod = 20'(r_sum) * 20'd683;

    always_comb begin
        rd_a_en   = 1'b0;
        rd_b_en   = 1'b0;
        rd_a_addr = i_idx;
        rd_b_addr = i_idx;
        wr_en     = 1'b0;
        wr_addr   = i_idx;
        wr_data   = cool_val;
        div_start = 1'b0;
        div_num   = DIV_NUM_W'(lfsr_step);
        div_den   = r_span;
        unique case (i_cmd.op)
            DP_SPAN_GO: begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'({i_cfg.cooling, 3'b000})
                          + DIV_NUM_W'({i_cfg.cooling, 1'b0});
                div_den   = DIV_DEN_W'(CELLS);
            end
            DP_COOL_GO: begin
                div_start = 1'b1;
                rd_a_en   = 1'b1;
            end
            DP_COOL_WR: begin
                wr_en = 1'b1;
            end
            DP_DIFF_RD: begin
                rd_a_en   = 1'b1;
                rd_b_en   = 1'b1;
                rd_a_addr = i_idx - AW'(1);
                rd_b_addr = i_idx - AW'(2);
            end
            DP_DIFF_WR: begin
                wr_en   = 1'b1;
                wr_data = diff_prod[18:11];
            end
            DP_SPARK_RD: begin
                rd_a_en   = 1'b1;
                rd_a_addr = r_spark_y;
            end
            DP_SPARK_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_spark_y;
                wr_data = r_rd_a + r_boost;
            end
            DP_EMIT_RD: begin
                rd_a_en = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_heat[wr_addr] <= wr_data;
        end
        if (rd_a_en) begin
            r_rd_a <= r_heat[rd_a_addr];
        end
        if (rd_b_en) begin
            r_rd_b <= r_heat[rd_b_addr];
        end
    end

    fhe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= SEED_RST;
            r_warm <= 1'b0;
        end else begin
            if (i_seed_load) begin
                r_lfsr <= (i_seed == '0) ? SEED_W'(1) : i_seed;
            end else if (i_cmd.op == DP_COOL_GO) begin
                r_lfsr <= lfsr_step;
            end
            if (i_cmd.op == DP_COOL_WR && i_cmd.last) begin
                r_warm <= 1'b1;
            end
        end
    end

    // Heat to color: tone = round(heat * 191 / 255).
    assign tone_x   = 16'(r_rd_a) * 16'd191 + 16'd127;
    assign tone_q   = 17'(tone_x) + 17'd1 + 17'(tone_x[15:8]);
    assign ramp     = {r_tone[5:0], 2'b00};
    assign band_hot = (r_tone > 8'h80);
    assign band_mid = (r_tone > 8'h40);

    always_comb begin
        unique case (i_cfg.palette)
            PAL_RED: begin
                if (band_hot) begin
                    red = 8'hFF; green = 8'hFF; blue = ramp;
                end else if (band_mid) begin
                    red = 8'hFF; green = ramp; blue = '0;
                end else begin
                    red = ramp; green = '0; blue = '0;
                end
            end
            PAL_GREEN: begin
                if (band_hot) begin
                    red = 8'hFF; green = 8'hFF; blue = ramp;
                end else if (band_mid) begin
                    red = ramp; green = 8'hFF; blue = '0;
                end else begin
                    red = '0; green = ramp; blue = '0;
                end
            end
            default: begin
                if (band_hot) begin
                    red = 8'hFF; green = ramp; blue = 8'hFF;
                end else if (band_mid) begin
                    red = ramp; green = '0; blue = 8'hFF;
                end else begin
                    red = '0; green = '0; blue = ramp;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_LATCH) begin
            r_hit     <= (in_roll < i_cfg.spark_thr);
            r_spark_y <= AW'(zone_v);
            r_boost   <= in_boost;
        end
        if (i_cmd.op == DP_SPAN_SET) begin
            r_span <= div_quot[DIV_DEN_W-1:0] + DIV_DEN_W'(2);
        end
        if (i_cmd.op == DP_DIFF_SUM) begin
            r_sum <= 10'(r_rd_a) + {1'b0, r_rd_b, 1'b0};
        end
        if (i_cmd.op == DP_EMIT_CALC) begin
            r_tone <= tone_q[15:8];
        end
        if (i_cmd.op == DP_EMIT_LD) begin
            r_out_data <= M_TDATA_W'({blue, green, red, PIX_W'(i_idx)});
            r_out_last <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == DP_EMIT_LD) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.div_busy  = div_busy;
    assign o_stat.out_free  = out_free;
    assign o_stat.spark_hit = r_hit;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

// ===== sv/fhe_ctrl.sv =====
// ----------------------------------------------------------------------------
// fhe_ctrl: fire effect sequencer
// Frame timing and the pass-by-pass walk over the heat cells.
// ----------------------------------------------------------------------------
module fhe_ctrl #(
    parameter int CELLS = fhe_pkg::CELLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [fhe_pkg::PERIOD_W-1:0]   i_frame_period,
    input  fhe_pkg::t_dp_stat              i_stat,
    output fhe_pkg::t_dp_cmd               o_cmd,
    output logic [$clog2(CELLS)-1:0]       o_idx
);
    import fhe_pkg::*;

    localparam int          AW   = $clog2(CELLS);
    localparam logic [AW-1:0] LAST = AW'(CELLS - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPAN_GO,
        ST_SPAN_WAIT,
        ST_COOL_GO,
        ST_COOL_WAIT,
        ST_COOL_WR,
        ST_DIFF_RD,
        ST_DIFF_SUM,
        ST_DIFF_WR,
        ST_SPARK_RD,
        ST_SPARK_WR,
        ST_EMIT_RD,
        ST_EMIT_CALC,
        ST_EMIT_LD
    } t_state;

    t_state              r_state;
    logic [AW-1:0]       r_idx;
    logic [PERIOD_W-1:0] r_ticks;
    logic                r_due;
    logic [PERIOD_W-1:0] n_ticks;
    logic                tick_hit;

    assign n_ticks  = r_ticks + PERIOD_W'(1);
    assign tick_hit = (n_ticks >= i_frame_period) || (n_ticks == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_ticks <= '0;
            r_due   <= 1'b1;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_s_tvalid) begin
                        r_ticks <= tick_hit ? '0 : n_ticks;
                        r_due   <= tick_hit;
                        if (r_due) begin
                            r_state <= ST_SPAN_GO;
                        end
                    end
                end
                ST_SPAN_GO: r_state <= ST_SPAN_WAIT;
                ST_SPAN_WAIT: begin
                    if (!i_stat.div_busy) begin
                        r_idx   <= '0;
                        r_state <= ST_COOL_GO;
                    end
                end
                ST_COOL_GO: r_state <= ST_COOL_WAIT;
                ST_COOL_WAIT: begin
                    if (!i_stat.div_busy) begin
                        r_state <= ST_COOL_WR;
                    end
                end
                ST_COOL_WR: begin
                    if (r_idx == LAST) begin
                        r_state <= ST_DIFF_RD;
                    end else begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= ST_COOL_GO;
                    end
                end
                ST_DIFF_RD:  r_state <= ST_DIFF_SUM;
                ST_DIFF_SUM: r_state <= ST_DIFF_WR;
                ST_DIFF_WR: begin
                    if (r_idx == AW'(2)) begin
                        r_idx   <= '0;
                        r_state <= i_stat.spark_hit ? ST_SPARK_RD : ST_EMIT_RD;
                    end else begin
                        r_idx   <= r_idx - AW'(1);
                        r_state <= ST_DIFF_RD;
                    end
                end
                ST_SPARK_RD: r_state <= ST_SPARK_WR;
                ST_SPARK_WR: r_state <= ST_EMIT_RD;
                ST_EMIT_RD:   r_state <= ST_EMIT_CALC;
                ST_EMIT_CALC: r_state <= ST_EMIT_LD;
                ST_EMIT_LD: begin
                    if (i_stat.out_free) begin
                        if (r_idx == LAST) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx   <= r_idx + AW'(1);
                            r_state <= ST_EMIT_RD;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd.op   = DP_NOP;
        o_cmd.last = (r_idx == LAST);
        unique case (r_state)
            ST_IDLE:      o_cmd.op = (i_s_tvalid && r_due) ? DP_LATCH : DP_NOP;
            ST_SPAN_GO:   o_cmd.op = DP_SPAN_GO;
            ST_SPAN_WAIT: o_cmd.op = i_stat.div_busy ? DP_NOP : DP_SPAN_SET;
            ST_COOL_GO:   o_cmd.op = DP_COOL_GO;
            ST_COOL_WAIT: o_cmd.op = DP_NOP;
            ST_COOL_WR:   o_cmd.op = DP_COOL_WR;
            ST_DIFF_RD:   o_cmd.op = DP_DIFF_RD;
            ST_DIFF_SUM:  o_cmd.op = DP_DIFF_SUM;
            ST_DIFF_WR:   o_cmd.op = DP_DIFF_WR;
            ST_SPARK_RD:  o_cmd.op = DP_SPARK_RD;
            ST_SPARK_WR:  o_cmd.op = DP_SPARK_WR;
            ST_EMIT_RD:   o_cmd.op = DP_EMIT_RD;
            ST_EMIT_CALC: o_cmd.op = DP_EMIT_CALC;
            ST_EMIT_LD:   o_cmd.op = i_stat.out_free ? DP_EMIT_LD : DP_NOP;
            default:      o_cmd.op = DP_NOP;
        endcase
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_idx      = r_idx;

endmodule

// ===== sv/fhe_chk.sv =====
// ----------------------------------------------------------------------------
// fhe_chk: port-level checks of the fire effect
// Watches the top-level ports over time; bound to every instance.
// ----------------------------------------------------------------------------
module fhe_chk #(
    parameter int CELLS = fhe_pkg::CELLS_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_s_axis_tready,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [fhe_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    input logic                           o_m_axis_tlast
);
    import fhe_pkg::*;

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result beat changed while stalled");

    // The frame marker sits on the top pixel only.
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |->
            o_m_axis_tdata[PIX_W-1:0] == PIX_W'(CELLS - 1))
        else $error("last pixel flag on wrong pixel");

    // While a frame is only partly out, no new tick is taken.
    a_busy_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> !o_s_axis_tready)
        else $error("tick accepted in the middle of a frame");

    // Nothing is offered right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result beat offered after reset");

endmodule

bind fire_heat_effect fhe_chk #(.CELLS(CELLS)) u_fhe_chk (.*);
